FILE: rtl/core/tpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpl_pkg
// Shared constants, codes and types of the thermocouple linearizer.
// ----------------------------------------------------------------------------
package tpl_pkg;

	localparam int MAX_POINTS  = 8;
	localparam int IDX_W       = $clog2(MAX_POINTS);
	localparam int PIDX_W      = 3;
	localparam int CNT_W       = 4;
	localparam int VAL_W       = 17;
	localparam int SMP_W       = 16;
	localparam int DIFF_W      = VAL_W + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int MAG_W       = 2 * VAL_W;
	localparam int RES_W       = MAG_W + 2;
	localparam int TEMP_MAX    = 100000;
	localparam int CAL_PRE_MAX = 75000;
	localparam int PRE_W       = VAL_W + 2;
	localparam int RECIP_W     = 20;
	localparam int RECIP       = 699051;
	localparam int RECIP_SH    = 21;
	localparam int SCL_W       = PRE_W + RECIP_W;

	typedef enum logic [1:0] {
		CMD_LOAD_SENSOR = 2'd0,
		CMD_LOAD_CAL    = 2'd1,
		CMD_CONVERT     = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_SENSOR_POINTS = 2'd0,
		CFG_CAL_POINTS    = 2'd1,
		CFG_CAL_ENABLE    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [PIDX_W-1:0] idx;
		logic [VAL_W-1:0]  px;
		logic [VAL_W-1:0]  py;
		logic [VAL_W-1:0]  temp;
		logic              sat;
	} item_t;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] r;
		r = n;
		if (int'(n) < 2) r = CNT_W'(2);
		else if (int'(n) > MAX_POINTS) r = CNT_W'(MAX_POINTS);
		return r;
	endfunction

endpackage

FILE: rtl/core/tpl_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpl_cfg_if
// Register write channel: index and data word.
// ----------------------------------------------------------------------------
interface tpl_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [tpl_pkg::CNT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/tpl_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpl_sample_if
// Command channel: load and convert words.
// ----------------------------------------------------------------------------
interface tpl_sample_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [tpl_pkg::PIDX_W-1:0] point_index;
	logic [tpl_pkg::VAL_W-1:0]  point_x;
	logic [tpl_pkg::VAL_W-1:0]  point_y;
	logic [tpl_pkg::SMP_W-1:0]  sample_uv;

	modport source (output valid, output command, output point_index, output point_x,
		output point_y, output sample_uv, input ready);
	modport sink (input valid, input command, input point_index, input point_x,
		input point_y, input sample_uv, output ready);
endinterface

FILE: rtl/core/tpl_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpl_result_if
// Result channel: temperature word with flags.
// ----------------------------------------------------------------------------
interface tpl_result_if;
	logic valid;
	logic ready;
	logic [tpl_pkg::VAL_W-1:0] temperature_centi;
	logic saturated;
	logic is_conversion;

	modport source (output valid, output temperature_centi, output saturated,
		output is_conversion, input ready);
	modport sink (input valid, input temperature_centi, input saturated,
		input is_conversion, output ready);
endinterface

FILE: rtl/core/thermocouple_piecewise_linearizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermocouple_piecewise_linearizer_core
// Microvolt to centidegree conversion with optional calibration correction.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the result is not stalled and returns one result
// word per command, in order. Two interpolation pipelines run in series, each with
// a 34-stage restoring divider, plus input, clamp, scale and output stages. Table
// loads travel the pipeline and write each table at its lookup stage, so every
// word sees the tables as left by the words ahead of it. A stalled result holds
// the whole pipeline.
module thermocouple_piecewise_linearizer_core (
	input  logic               clk,
	input  logic               arst_n,
	tpl_cfg_if.sink            cfg,
	tpl_sample_if.sink         sample,
	tpl_result_if.source       result
);
	import tpl_pkg::*;

	localparam logic signed [RES_W-1:0] TMAX_R = RES_W'(TEMP_MAX);
	localparam logic signed [RES_W-1:0] CMAX_R = RES_W'(CAL_PRE_MAX);

	logic [CNT_W-1:0] sensor_points_q, cal_points_q;
	logic             cal_enable_q;
	logic             adv;
	logic             v_s4;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_points_q <= CNT_W'(6);
			cal_points_q    <= CNT_W'(5);
			cal_enable_q    <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SENSOR_POINTS: sensor_points_q <= cfg.data;
				CFG_CAL_POINTS:    cal_points_q    <= cfg.data;
				CFG_CAL_ENABLE:    cal_enable_q    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign adv          = !v_s4 || result.ready;
	assign sample.ready = adv;

	logic             v_s0;
	item_t            item_s0;
	logic [VAL_W-1:0] x_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s0 <= 1'b0;
		else if (adv) v_s0 <= sample.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s0.cmd  <= sample.command;
			item_s0.idx  <= sample.point_index;
			item_s0.px   <= sample.point_x;
			item_s0.py   <= sample.point_y;
			item_s0.temp <= '0;
			item_s0.sat  <= 1'b0;
			x_s0         <= VAL_W'(sample.sample_uv);
		end
	end

	logic                    sv_valid;
	item_t                   sv_item;
	logic signed [RES_W-1:0] sv_r;

	tpl_interp u_sensor (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.wr_cmd    (CMD_LOAD_SENSOR),
		.count     (sensor_points_q),
		.in_valid  (v_s0),
		.in_item   (item_s0),
		.in_x      (x_s0),
		.out_valid (sv_valid),
		.out_item  (sv_item),
		.out_r     (sv_r)
	);

	logic [VAL_W-1:0] t1;
	logic             sat1;
	logic [VAL_W+1:0] t1x3;

	always_comb begin
		sat1 = 1'b0;
		t1   = sv_r[VAL_W-1:0];
		if (sv_r < 0) begin
			sat1 = 1'b1;
			t1   = '0;
		end else if (sv_r > TMAX_R) begin
			sat1 = 1'b1;
			t1   = VAL_W'(TEMP_MAX);
		end
		t1x3 = {2'b00, t1} + {1'b0, t1, 1'b0};
	end

	logic             v_s1;
	item_t            item_s1;
	logic [VAL_W-1:0] cx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= sv_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= '{cmd: sv_item.cmd, idx: sv_item.idx, px: sv_item.px,
				py: sv_item.py, temp: t1, sat: sat1};
			cx_s1   <= t1x3[VAL_W+1:2];
		end
	end

	logic                    cv_valid;
	item_t                   cv_item;
	logic signed [RES_W-1:0] cv_r;

	tpl_interp u_cal (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.wr_cmd    (CMD_LOAD_CAL),
		.count     (cal_points_q),
		.in_valid  (v_s1),
		.in_item   (item_s1),
		.in_x      (cx_s1),
		.out_valid (cv_valid),
		.out_item  (cv_item),
		.out_r     (cv_r)
	);

	// clamp ahead of the 4/3 scale: above 75000 the scaled value exceeds range
	logic [VAL_W-1:0] pre;
	logic             sat2;

	always_comb begin
		sat2 = 1'b0;
		pre  = cv_r[VAL_W-1:0];
		if (cv_r < 0) begin
			sat2 = 1'b1;
			pre  = '0;
		end else if (cv_r > CMAX_R) begin
			sat2 = 1'b1;
			pre  = VAL_W'(CAL_PRE_MAX);
		end
	end

	logic             v_s2, sat2_s2;
	item_t            item_s2;
	logic [VAL_W-1:0] pre_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= cv_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= cv_item;
			sat2_s2 <= sat2;
			pre_s2  <= pre;
		end
	end

	logic             v_s3, sat2_s3;
	item_t            item_s3;
	logic [SCL_W-1:0] scl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s3 <= item_s2;
			sat2_s3 <= sat2_s2;
			scl_s3  <= SCL_W'({pre_s2, 2'b00}) * SCL_W'(RECIP);
		end
	end

	logic [VAL_W-1:0] temp_s4;
	logic             sat_s4, conv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (item_s3.cmd != CMD_CONVERT) begin
				temp_s4 <= '0;
				sat_s4  <= 1'b0;
				conv_s4 <= 1'b0;
			end else if (cal_enable_q) begin
				temp_s4 <= scl_s3[RECIP_SH +: VAL_W];
				sat_s4  <= item_s3.sat | sat2_s3;
				conv_s4 <= 1'b1;
			end else begin
				temp_s4 <= item_s3.temp;
				sat_s4  <= item_s3.sat;
				conv_s4 <= 1'b1;
			end
		end
	end

	assign result.valid             = v_s4;
	assign result.temperature_centi = temp_s4;
	assign result.saturated         = sat_s4;
	assign result.is_conversion     = conv_s4;

`ifndef NO_ASSERTIONS
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.is_conversion |->
		result.temperature_centi == '0 && !result.saturated)
		else $error("acknowledge word carries data");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.temperature_centi <= VAL_W'(TEMP_MAX))
		else $error("temperature out of range");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready == (!result.valid || result.ready))
		else $error("input ready does not follow output stall");
`endif
endmodule

FILE: rtl/core/tpl_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpl_interp
// Point table with pipelined segment search, multiply and restoring divide.
// ----------------------------------------------------------------------------
module tpl_interp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [1:0]                  wr_cmd,
	input  logic [tpl_pkg::CNT_W-1:0]   count,
	input  logic                        in_valid,
	input  tpl_pkg::item_t              in_item,
	input  logic [tpl_pkg::VAL_W-1:0]   in_x,
	output logic                        out_valid,
	output tpl_pkg::item_t              out_item,
	output logic signed [tpl_pkg::RES_W-1:0] out_r
);
	import tpl_pkg::*;

	logic [VAL_W-1:0] xs_q [MAX_POINTS];
	logic [VAL_W-1:0] ys_q [MAX_POINTS];

	logic [CNT_W-1:0] n;
	logic [IDX_W-1:0] last;
	logic [IDX_W-1:0] seg;
	logic             below, above, found, direct;

	always_ff @(posedge clk) begin
		if (adv && in_valid && in_item.cmd == wr_cmd && int'(in_item.idx) < MAX_POINTS) begin
			xs_q[IDX_W'(in_item.idx)] <= in_item.px;
			ys_q[IDX_W'(in_item.idx)] <= in_item.py;
		end
	end

	always_comb begin
		n     = clamp_count(count);
		last  = IDX_W'(n - CNT_W'(1));
		below = in_x <= xs_q[0];
		above = in_x >= xs_q[last];
		found = 1'b0;
		seg   = '0;
		for (int i = MAX_POINTS - 2; i >= 0; i--) begin
			if (i + 1 < int'(n) && xs_q[i] <= in_x && in_x < xs_q[i+1]) begin
				found = 1'b1;
				seg   = IDX_W'(i);
			end
		end
		if (above) seg = last - IDX_W'(1);
		direct = below || (!above && !found);
	end

	logic             v_s1, hold_s1;
	item_t            item_s1;
	logic [VAL_W-1:0] x_s1, x0_s1, x1_s1, y0_s1, y1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_item;
			x_s1    <= in_x;
			x0_s1   <= xs_q[seg];
			x1_s1   <= xs_q[seg + IDX_W'(1)];
			y0_s1   <= direct ? ys_q[0] : ys_q[seg];
			y1_s1   <= ys_q[seg + IDX_W'(1)];
			hold_s1 <= direct;
		end
	end

	logic                     v_s2, hold_s2;
	item_t                    item_s2;
	logic [VAL_W-1:0]         y0_s2;
	logic signed [DIFF_W-1:0] dy_s2, dx_s2, den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= item_s1;
			y0_s2   <= y0_s1;
			hold_s2 <= hold_s1 || (x1_s1 == x0_s1);
			dy_s2   <= $signed({1'b0, y1_s1}) - $signed({1'b0, y0_s1});
			dx_s2   <= $signed({1'b0, x_s1}) - $signed({1'b0, x0_s1});
			den_s2  <= $signed({1'b0, x1_s1}) - $signed({1'b0, x0_s1});
		end
	end

	logic                     v_s3, hold_s3;
	item_t                    item_s3;
	logic [VAL_W-1:0]         y0_s3;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [DIFF_W-1:0] den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s3 <= item_s2;
			y0_s3   <= y0_s2;
			hold_s3 <= hold_s2;
			prod_s3 <= dy_s2 * dx_s2;
			den_s3  <= den_s2;
		end
	end

	logic              v_s4, hold_s4, neg_s4;
	item_t             item_s4;
	logic [VAL_W-1:0]  y0_s4, dmag_s4;
	logic [MAG_W-1:0]  mag_s4;
	logic [PROD_W-1:0] prod_abs;
	logic [DIFF_W-1:0] den_abs;

	assign prod_abs = prod_s3[PROD_W-1] ? PROD_W'(-prod_s3) : PROD_W'(prod_s3);
	assign den_abs  = den_s3[DIFF_W-1] ? DIFF_W'(-den_s3) : DIFF_W'(den_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s4 <= item_s3;
			y0_s4   <= y0_s3;
			hold_s4 <= hold_s3;
			neg_s4  <= prod_s3[PROD_W-1] ^ den_s3[DIFF_W-1];
			mag_s4  <= prod_abs[MAG_W-1:0];
			dmag_s4 <= den_abs[VAL_W-1:0];
		end
	end

	// restoring divide, one quotient bit per stage
	logic             st_v    [MAG_W+1];
	logic             st_hold [MAG_W+1];
	logic             st_neg  [MAG_W+1];
	item_t            st_item [MAG_W+1];
	logic [VAL_W-1:0] st_y0   [MAG_W+1];
	logic [VAL_W-1:0] st_d    [MAG_W+1];
	logic [VAL_W-1:0] st_rem  [MAG_W+1];
	logic [MAG_W-1:0] st_aq   [MAG_W+1];

	assign st_v[0]    = v_s4;
	assign st_hold[0] = hold_s4;
	assign st_neg[0]  = neg_s4;
	assign st_item[0] = item_s4;
	assign st_y0[0]   = y0_s4;
	assign st_d[0]    = dmag_s4;
	assign st_rem[0]  = '0;
	assign st_aq[0]   = mag_s4;

	logic             div_v_s5    [MAG_W];
	logic             div_hold_s5 [MAG_W];
	logic             div_neg_s5  [MAG_W];
	item_t            div_item_s5 [MAG_W];
	logic [VAL_W-1:0] div_y0_s5   [MAG_W];
	logic [VAL_W-1:0] div_d_s5    [MAG_W];
	logic [VAL_W-1:0] div_rem_s5  [MAG_W];
	logic [MAG_W-1:0] div_aq_s5   [MAG_W];

	for (genvar k = 0; k < MAG_W; k++) begin : g_div
		logic [VAL_W:0] trial;
		logic           ge;

		assign trial = {st_rem[k], st_aq[k][MAG_W-1]};
		assign ge    = trial >= {1'b0, st_d[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_v_s5[k] <= 1'b0;
			else if (adv) div_v_s5[k] <= st_v[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_hold_s5[k] <= st_hold[k];
				div_neg_s5[k]  <= st_neg[k];
				div_item_s5[k] <= st_item[k];
				div_y0_s5[k]   <= st_y0[k];
				div_d_s5[k]    <= st_d[k];
				div_rem_s5[k]  <= ge ? VAL_W'(trial - {1'b0, st_d[k]}) : trial[VAL_W-1:0];
				div_aq_s5[k]   <= {st_aq[k][MAG_W-2:0], ge};
			end
		end

		assign st_v[k+1]    = div_v_s5[k];
		assign st_hold[k+1] = div_hold_s5[k];
		assign st_neg[k+1]  = div_neg_s5[k];
		assign st_item[k+1] = div_item_s5[k];
		assign st_y0[k+1]   = div_y0_s5[k];
		assign st_d[k+1]    = div_d_s5[k];
		assign st_rem[k+1]  = div_rem_s5[k];
		assign st_aq[k+1]   = div_aq_s5[k];
	end

	logic signed [RES_W-1:0] q_mag, q_sgn, y0_ext;

	assign q_mag  = $signed({{(RES_W-MAG_W){1'b0}}, st_aq[MAG_W]});
	assign q_sgn  = st_hold[MAG_W] ? '0 : (st_neg[MAG_W] ? -q_mag : q_mag);
	assign y0_ext = $signed({{(RES_W-VAL_W){1'b0}}, st_y0[MAG_W]});

	logic                    v_s6;
	item_t                   item_s6;
	logic signed [RES_W-1:0] r_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= st_v[MAG_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s6 <= st_item[MAG_W];
			r_s6    <= y0_ext + q_sgn;
		end
	end

	assign out_valid = v_s6;
	assign out_item  = item_s6;
	assign out_r     = r_s6;
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the thermocouple piecewise linearizer core.
// A table of directed words runs first. Three random phases follow, each
// with its own register settings and reloaded point tables. A local model of
// the tables and the interpolation predicts the words the directed rows do not
// give; results are checked in order against a queue of pending temperatures.
// ----------------------------------------------------------------------------
module tb_top;
	import tpl_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 120;
	localparam int PHASE_WORDS = 670;

	typedef struct packed {
		logic [VAL_W-1:0] temp;
		logic             sat;
		logic             conv;
	} temp_word_t;

	typedef struct {
		logic [1:0]        cmd;
		logic [PIDX_W-1:0] idx;
		logic [VAL_W-1:0]  px;
		logic [VAL_W-1:0]  py;
		logic [SMP_W-1:0]  smp;
		bit                typed;
		temp_word_t        want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tpl_cfg_if    cfg_if ();
	tpl_sample_if smp_if ();
	tpl_result_if res_if ();

	thermocouple_piecewise_linearizer_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.sample (smp_if),
		.result (res_if)
	);

	always #5 clk = ~clk;

	// local copy of block state: table 0 is sensor, table 1 is calibration
	logic [VAL_W-1:0] pt_x [2][MAX_POINTS];
	logic [VAL_W-1:0] pt_y [2][MAX_POINTS];
	logic [CNT_W-1:0] n_sensor = 4'd6;
	logic [CNT_W-1:0] n_cal = 4'd5;
	logic             cal_on = 1'b0;

	temp_word_t pending_temps [$];
	int errors = 0;
	int cycles = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	function automatic int used_points(input logic [CNT_W-1:0] n);
		if (n < 2) return 2;
		if (n > MAX_POINTS) return MAX_POINTS;
		return int'(n);
	endfunction

	function automatic longint lerp(input int t, input int n, input longint x);
		int seg;
		bit found;
		longint x0, x1, y0, y1;
		seg = 0;
		found = 1'b0;
		if (x <= longint'(pt_x[t][0])) return longint'(pt_y[t][0]);
		if (x >= longint'(pt_x[t][n-1])) begin
			seg = n - 2;
		end else begin
			for (int i = 0; i + 1 < n; i++) begin
				if (!found && longint'(pt_x[t][i]) <= x && x < longint'(pt_x[t][i+1])) begin
					seg = i;
					found = 1'b1;
				end
			end
			if (!found) return longint'(pt_y[t][0]);
		end
		x0 = pt_x[t][seg];
		x1 = pt_x[t][seg+1];
		y0 = pt_y[t][seg];
		y1 = pt_y[t][seg+1];
		if (x1 == x0) return y0;
		return y0 + ((y1 - y0) * (x - x0)) / (x1 - x0);
	endfunction

	function automatic longint clamp_temp(input longint v, inout logic sat);
		if (v < 0) begin
			sat = 1'b1;
			return 0;
		end
		if (v > TEMP_MAX) begin
			sat = 1'b1;
			return TEMP_MAX;
		end
		return v;
	endfunction

	function automatic temp_word_t predict_temp(input logic [1:0] cmd,
			input logic [PIDX_W-1:0] idx, input logic [VAL_W-1:0] px,
			input logic [VAL_W-1:0] py, input logic [SMP_W-1:0] smp);
		temp_word_t w;
		logic sat;
		longint t;
		w = '0;
		sat = 1'b0;
		if (cmd == CMD_LOAD_SENSOR || cmd == CMD_LOAD_CAL) begin
			pt_x[cmd == CMD_LOAD_CAL][idx] = px;
			pt_y[cmd == CMD_LOAD_CAL][idx] = py;
		end else if (cmd == CMD_CONVERT) begin
			t = clamp_temp(lerp(0, used_points(n_sensor), longint'(smp)), sat);
			if (cal_on)
				t = clamp_temp((lerp(1, used_points(n_cal), (t * 3) / 4) * 4) / 3, sat);
			w.temp = t[VAL_W-1:0];
			w.sat = sat;
			w.conv = 1'b1;
		end
		return w;
	endfunction

	task automatic send_word(input logic [1:0] cmd, input logic [PIDX_W-1:0] idx,
			input logic [VAL_W-1:0] px, input logic [VAL_W-1:0] py,
			input logic [SMP_W-1:0] smp, input bit typed, input temp_word_t want);
		int gap;
		temp_word_t w;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct) gap++;
		if (gap > 0) begin
			smp_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_if.valid <= 1'b1;
		smp_if.command <= cmd;
		smp_if.point_index <= idx;
		smp_if.point_x <= px;
		smp_if.point_y <= py;
		smp_if.sample_uv <= smp;
		@(posedge clk);
		while (!smp_if.ready) @(posedge clk);
		w = predict_temp(cmd, idx, px, py, smp);
		pending_temps.push_back(typed ? want : w);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CNT_W-1:0] d);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= r;
		cfg_if.data <= d;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		case (r)
			CFG_SENSOR_POINTS: n_sensor = d;
			CFG_CAL_POINTS: n_cal = d;
			default: cal_on = d[0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		smp_if.valid <= 1'b0;
		while (pending_temps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reload_tables(input int t, input int xmax);
		logic [VAL_W-1:0] xs [MAX_POINTS];
		for (int i = 0; i < MAX_POINTS; i++) xs[i] = $urandom_range(xmax);
		xs.sort();
		for (int i = 1; i < MAX_POINTS; i++)
			if ($urandom_range(9) == 0) xs[i] = xs[i-1];
		if ($urandom_range(7) == 0) xs.shuffle();
		for (int i = 0; i < MAX_POINTS; i++)
			send_word(t ? CMD_LOAD_CAL : CMD_LOAD_SENSOR, PIDX_W'(i), xs[i],
				VAL_W'($urandom_range(TEMP_MAX)), '0, 1'b0, '0);
	endtask

	task automatic random_words(input int count);
		int sel, t, i;
		logic [SMP_W-1:0] smp;
		for (int k = 0; k < count; k++) begin
			sel = $urandom_range(99);
			if (sel < 80) begin
				smp = $urandom_range(65535);
				i = $urandom_range(MAX_POINTS - 1);
				if ($urandom_range(5) == 0 && pt_x[0][i] <= 65535) smp = pt_x[0][i][SMP_W-1:0];
				send_word(CMD_CONVERT, PIDX_W'($urandom_range(7)), VAL_W'($urandom_range(TEMP_MAX)),
					VAL_W'($urandom_range(TEMP_MAX)), smp, 1'b0, '0);
			end else if (sel < 92) begin
				t = $urandom_range(1);
				i = $urandom_range(MAX_POINTS - 1);
				send_word(t ? CMD_LOAD_CAL : CMD_LOAD_SENSOR, PIDX_W'(i), pt_x[t][i],
					VAL_W'($urandom_range(TEMP_MAX)), SMP_W'($urandom), 1'b0, '0);
			end else if (sel < 96) begin
				send_word(logic'($urandom_range(1)) ? CMD_LOAD_CAL : CMD_LOAD_SENSOR,
					PIDX_W'($urandom_range(7)), VAL_W'($urandom_range(TEMP_MAX)),
					VAL_W'($urandom_range(TEMP_MAX)), SMP_W'($urandom), 1'b0, '0);
			end else begin
				send_word(CMD_UNUSED, PIDX_W'($urandom), VAL_W'($urandom_range(TEMP_MAX)),
					VAL_W'($urandom_range(TEMP_MAX)), SMP_W'($urandom), 1'b0, '0);
			end
		end
	endtask

	always @(posedge clk) begin
		temp_word_t got, want;
		if (res_if.valid && res_if.ready) begin
			got = '{res_if.temperature_centi, res_if.saturated, res_if.is_conversion};
			if (pending_temps.size() == 0) begin
				$display("%0t: unexpected result word temp=%0d sat=%0b conv=%0b",
					$time, got.temp, got.sat, got.conv);
				errors++;
			end else begin
				want = pending_temps.pop_front();
				if (got.temp !== want.temp)
					$display("%0t: temperature_centi expected %0d actual %0d",
						$time, want.temp, got.temp);
				if (got.sat !== want.sat)
					$display("%0t: saturated expected %0b actual %0b", $time, want.sat, got.sat);
				if (got.conv !== want.conv)
					$display("%0t: is_conversion expected %0b actual %0b",
						$time, want.conv, got.conv);
				if (got !== want) errors++;
			end
		end
		res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	stim_row_t dir_rows [] = '{
		'{CMD_LOAD_SENSOR, 3'd0,  1000,   500, 0, 1, '{0, 0, 0}},
		'{CMD_LOAD_SENSOR, 3'd1,  8000, 15000, 0, 1, '{0, 0, 0}},
		'{CMD_LOAD_SENSOR, 3'd2, 16000, 30000, 0, 1, '{0, 0, 0}},
		'{CMD_LOAD_SENSOR, 3'd3, 24000, 45000, 0, 1, '{0, 0, 0}},
		'{CMD_LOAD_SENSOR, 3'd4, 32000, 60000, 0, 1, '{0, 0, 0}},
		'{CMD_LOAD_SENSOR, 3'd5, 40000, 75000, 0, 1, '{0, 0, 0}},
		'{CMD_UNUSED, 3'd7, 100000, 100000, 65535, 1, '{0, 0, 0}},
		'{CMD_CONVERT, 3'd0, 0, 0, 0, 1, '{500, 0, 1}},
		'{CMD_CONVERT, 3'd0, 0, 0, 1000, 1, '{500, 0, 1}},
		'{CMD_CONVERT, 3'd0, 0, 0, 16000, 1, '{30000, 0, 1}},
		'{CMD_CONVERT, 3'd0, 0, 0, 65535, 1, '{100000, 1, 1}},
		'{CMD_CONVERT, 3'd7, 100000, 100000, 12345, 0, '{0, 0, 0}},
		'{CMD_CONVERT, 3'd0, 0, 0, 39999, 0, '{0, 0, 0}},
		'{CMD_LOAD_SENSOR, 3'd5, 32000, 1, 0, 1, '{0, 0, 0}},
		'{CMD_CONVERT, 3'd0, 0, 0, 50000, 1, '{60000, 0, 1}},
		'{CMD_LOAD_SENSOR, 3'd5, 40000, 0, 0, 1, '{0, 0, 0}},
		'{CMD_CONVERT, 3'd0, 0, 0, 65535, 1, '{0, 1, 1}},
		'{CMD_CONVERT, 3'd0, 0, 0, 36000, 0, '{0, 0, 0}}
	};

	initial begin
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		smp_if.valid = 1'b0;
		smp_if.command = '0;
		smp_if.point_index = '0;
		smp_if.point_x = '0;
		smp_if.point_y = '0;
		smp_if.sample_uv = '0;
		res_if.ready = 1'b0;
		for (int t = 0; t < 2; t++)
			for (int i = 0; i < MAX_POINTS; i++) begin
				pt_x[t][i] = '0;
				pt_y[t][i] = '0;
			end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[r])
			send_word(dir_rows[r].cmd, dir_rows[r].idx, dir_rows[r].px, dir_rows[r].py,
				dir_rows[r].smp, dir_rows[r].typed, dir_rows[r].want);

		for (int ph = 0; ph < 3; ph++) begin
			drain();
			tx_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 84 : 0;
			rx_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 23 : 0;
			case (ph)
				0: begin
					write_reg(CFG_SENSOR_POINTS, 4'd8);
					write_reg(CFG_CAL_POINTS, 4'd2);
					write_reg(CFG_CAL_ENABLE, 4'd1);
				end
				1: begin
					write_reg(CFG_SENSOR_POINTS, 4'd0);
					write_reg(CFG_CAL_POINTS, 4'd15);
					write_reg(CFG_CAL_ENABLE, 4'd1);
				end
				default: begin
					write_reg(CFG_SENSOR_POINTS, CNT_W'($urandom));
					write_reg(CFG_CAL_POINTS, CNT_W'($urandom));
					write_reg(CFG_CAL_ENABLE, 4'd0);
				end
			endcase
			reload_tables(0, 70000);
			reload_tables(1, 80000);
			random_words(PHASE_WORDS / 2);
			drain();
			if (ph == 2) write_reg(CFG_CAL_ENABLE, 4'd1);
			random_words(PHASE_WORDS / 2);
		end

		drain();
		if (errors == 0 && pending_temps.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/tpl_pkg.sv
rtl/core/tpl_cfg_if.sv
rtl/core/tpl_sample_if.sv
rtl/core/tpl_result_if.sv
rtl/core/tpl_interp.sv
rtl/core/thermocouple_piecewise_linearizer_core.sv
tb/tb_top.sv
